// ===== rtl/core/cdl_pkg.sv =====
// Shared types and constants for the CoDel dequeue drop decision block.
`default_nettype none

package cdl_pkg;

    // Width of the time arithmetic; all times wrap modulo 2^TIME_WIDTH (32..64).
    localparam int TIME_WIDTH = 64;

    // Fixed port widths.
    localparam int TS_W     = 64;
    localparam int CNT_W    = 7;
    localparam int REG_W    = 32;
    localparam int INV_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W    = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] TARGET_DELAY_RST = 32'd5000000;
    localparam logic [REG_W-1:0] INTERVAL_RST     = 32'd100000000;

    // Constant 3.0 in the Q32 format of the Newton step.
    localparam logic [2*MUL_W-1:0] NEWTON_THREE = 64'h0000_0003_0000_0000;

    typedef logic [TIME_WIDTH-1:0]   tick_t;
    typedef logic [TIME_WIDTH+3:0]   cmp_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/cdl_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
`default_nettype none

module cdl_mul
(
    input  wire logic                  clk,
    input  wire cdl_pkg::mul_req_t     req,
    output logic [2*cdl_pkg::MUL_W-1:0] prod
);

    logic [2*cdl_pkg::MUL_W-1:0] prod_reg;

    // The product register holds its value while no request is made.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/codel_dequeue_drop_decision.sv =====
// Top level of the CoDel drop decision block for burst dequeue events.
//
// The block takes one item per burst dequeue event on the input channel
// (in_valid / in_ready): the number of packets dequeued, the arrival time of
// the head packet and the current time. For each item it returns exactly one
// item on the output channel (out_valid / out_ready): the drop decision, the
// sojourn time and the running total of drops.
//
// An empty burst goes from evaluation straight to the result, a burst that
// leaves the control law alone passes evaluation and planning, a fresh entry
// into the dropping state adds the control law and next-drop steps, and a
// burst that runs the Newton step passes the Newton multiplier steps first.
// The single shared 32 x 32 multiplier, which the sequencer uses up to five
// times per item, sets the pace; in_ready is high only while the sequencer
// is idle, so a new item is taken only once the last result is registered.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits. If the receiver stalls and a second result
// is ready, the sequencer holds in its final state until the slot frees.
// Reset returns all CoDel state to zero and the two configuration registers
// to their defaults. The configuration port is always ready and must only be
// written while the block is idle.
`default_nettype none

module codel_dequeue_drop_decision
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cdl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cdl_pkg::REG_W-1:0]        cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [cdl_pkg::CNT_W-1:0]        dequeued_count,
    input  wire logic [cdl_pkg::TS_W-1:0]         head_timestamp,
    input  wire logic [cdl_pkg::TS_W-1:0]         now_time,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  drop,
    output logic [cdl_pkg::TS_W-1:0]              sojourn_time,
    output logic [cdl_pkg::REG_W-1:0]             total_drops
);

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_EVAL = 12'b0000_0000_0010,
        S_PLAN = 12'b0000_0000_0100,
        S_M1   = 12'b0000_0000_1000,
        S_M2   = 12'b0000_0001_0000,
        S_W    = 12'b0000_0010_0000,
        S_M3   = 12'b0000_0100_0000,
        S_M4   = 12'b0000_1000_0000,
        S_NEWT = 12'b0001_0000_0000,
        S_LAW  = 12'b0010_0000_0000,
        S_NEXT = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    localparam int PROD_W = 2 * cdl_pkg::MUL_W;

    // Control and CoDel state.
    state_t                          state_reg,    state_next;
    logic [cdl_pkg::REG_W-1:0]       target_reg,   target_next;
    logic [cdl_pkg::REG_W-1:0]       interval_reg, interval_next;
    cdl_pkg::tick_t                  fat_reg,      fat_next;
    logic                            dropping_reg, dropping_next;
    cdl_pkg::tick_t                  dnt_reg,      dnt_next;
    logic [cdl_pkg::REG_W-1:0]       dc_reg,       dc_next;
    logic [cdl_pkg::REG_W-1:0]       ldc_reg,      ldc_next;
    logic [cdl_pkg::INV_W-1:0]       inv_reg,      inv_next;
    logic [cdl_pkg::REG_W-1:0]       total_reg,    total_next;
    logic                            ovalid_reg,   ovalid_next;

    // Per-item working registers.
    logic                            empty_reg;
    cdl_pkg::tick_t                  now_reg;
    cdl_pkg::tick_t                  soj_reg;
    cdl_pkg::tick_t                  since_reg;
    logic                            ge_reg;
    logic                            drop_reg;
    logic                            base_now_reg;
    logic [46:0]                     v_reg;
    logic [46:0]                     acc_reg;

    // Output payload registers.
    logic                            odrop_reg;
    logic [cdl_pkg::TS_W-1:0]        osoj_reg;
    logic [cdl_pkg::REG_W-1:0]       ototal_reg;

    cdl_pkg::mul_req_t               mreq;
    logic [PROD_W-1:0]               prod;

    logic                            in_fire;
    logic                            out_slot_free;
    logic                            drop_now;
    logic [cdl_pkg::REG_W-1:0]       delta;
    logic                            rejoin;
    logic [PROD_W-1:0]               wval;
    logic [46:0]                     nsum;
    cdl_pkg::tick_t                  base;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign out_slot_free = !ovalid_reg || out_ready;

    // The sojourn test: below target clears the marker, the first time at or above
    // target arms it one interval ahead, and once past it the burst drops.
    assign drop_now = !empty_reg
                   && (soj_reg >= cdl_pkg::tick_t'(target_reg))
                   && (fat_reg != '0)
                   && (now_reg > fat_reg);

    // Re-entry shortly after leaving the dropping state resumes the count.
    assign delta  = dc_reg - ldc_reg;
    assign rejoin = (delta > 32'd1)
                 && (cdl_pkg::cmp_t'(since_reg) < cdl_pkg::cmp_t'({interval_reg, 4'b0000}));

    // Newton step pieces: 3 - count * r^2, then the two halves of v * inv.
    assign wval = cdl_pkg::NEWTON_THREE - prod;
    assign nsum = acc_reg + {prod[14:0], 32'd0};

    assign base = base_now_reg ? now_reg : dnt_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mreq = '0;
        case (state_reg)
            S_M1:
            begin
                mreq.en = 1'b1;
                mreq.a  = cdl_pkg::MUL_W'(inv_reg);
                mreq.b  = cdl_pkg::MUL_W'(inv_reg);
            end
            S_M2:
            begin
                mreq.en = 1'b1;
                mreq.a  = dc_reg;
                mreq.b  = prod[cdl_pkg::MUL_W-1:0];
            end
            S_M3:
            begin
                mreq.en = 1'b1;
                mreq.a  = v_reg[31:0];
                mreq.b  = cdl_pkg::MUL_W'(inv_reg);
            end
            S_M4:
            begin
                mreq.en = 1'b1;
                mreq.a  = cdl_pkg::MUL_W'(v_reg[46:32]);
                mreq.b  = cdl_pkg::MUL_W'(inv_reg);
            end
            S_LAW:
            begin
                mreq.en = 1'b1;
                mreq.a  = interval_reg;
                mreq.b  = cdl_pkg::MUL_W'(inv_reg);
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    cdl_mul u_mul
    (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // Next-state logic for control and CoDel state.
    always_comb
    begin
        state_next    = state_reg;
        target_next   = target_reg;
        interval_next = interval_reg;
        fat_next      = fat_reg;
        dropping_next = dropping_reg;
        dnt_next      = dnt_reg;
        dc_next       = dc_reg;
        ldc_next      = ldc_reg;
        inv_next      = inv_reg;
        total_next    = total_reg;
        ovalid_next   = ovalid_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cdl_pkg::REG_TARGET_DELAY)
            begin
                target_next = cfg_data;
            end
            else if (cfg_index == cdl_pkg::REG_INTERVAL)
            begin
                interval_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (empty_reg)
                begin
                    fat_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    if (soj_reg < cdl_pkg::tick_t'(target_reg))
                    begin
                        fat_next = '0;
                    end
                    else if (fat_reg == '0)
                    begin
                        fat_next = now_reg + cdl_pkg::tick_t'(interval_reg);
                    end
                    total_next = total_reg + cdl_pkg::REG_W'(drop_now);
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                state_next = S_DONE;
                if (dropping_reg)
                begin
                    if (!drop_reg)
                    begin
                        dropping_next = 1'b0;
                    end
                    else if (ge_reg)
                    begin
                        dc_next    = dc_reg + 32'd1;
                        state_next = S_M1;
                    end
                end
                else if (drop_reg)
                begin
                    dropping_next = 1'b1;
                    if (rejoin)
                    begin
                        dc_next    = delta;
                        ldc_next   = delta;
                        state_next = S_M1;
                    end
                    else
                    begin
                        dc_next    = 32'd1;
                        ldc_next   = 32'd1;
                        inv_next   = '1;
                        state_next = S_LAW;
                    end
                end
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                state_next = S_W;
            end
            S_W:
            begin
                state_next = S_M3;
            end
            S_M3:
            begin
                state_next = S_M4;
            end
            S_M4:
            begin
                state_next = S_NEWT;
            end
            S_NEWT:
            begin
                inv_next   = nsum[46:31];
                state_next = S_LAW;
            end
            S_LAW:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                dnt_next   = base + cdl_pkg::tick_t'(prod[47:16]);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_slot_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            target_reg   <= cdl_pkg::TARGET_DELAY_RST;
            interval_reg <= cdl_pkg::INTERVAL_RST;
            fat_reg      <= '0;
            dropping_reg <= 1'b0;
            dnt_reg      <= '0;
            dc_reg       <= '0;
            ldc_reg      <= '0;
            inv_reg      <= '0;
            total_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            target_reg   <= target_next;
            interval_reg <= interval_next;
            fat_reg      <= fat_next;
            dropping_reg <= dropping_next;
            dnt_reg      <= dnt_next;
            dc_reg       <= dc_next;
            ldc_reg      <= ldc_next;
            inv_reg      <= inv_next;
            total_reg    <= total_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            empty_reg <= (dequeued_count == '0);
            now_reg   <= now_time[cdl_pkg::TIME_WIDTH-1:0];
            soj_reg   <= now_time[cdl_pkg::TIME_WIDTH-1:0]
                       - head_timestamp[cdl_pkg::TIME_WIDTH-1:0];
        end
        if (state_reg == S_EVAL)
        begin
            drop_reg  <= drop_now;
            since_reg <= now_reg - dnt_reg;
            ge_reg    <= (now_reg >= dnt_reg);
            if (empty_reg)
            begin
                soj_reg <= '0;
            end
        end
        if (state_reg == S_PLAN)
        begin
            base_now_reg <= !dropping_reg;
        end
        if (state_reg == S_W)
        begin
            v_reg <= wval[48:2];
        end
        if (state_reg == S_M4)
        begin
            acc_reg <= prod[46:0];
        end
        if ((state_reg == S_DONE) && out_slot_free)
        begin
            odrop_reg  <= drop_reg && !empty_reg;
            osoj_reg   <= cdl_pkg::TS_W'(soj_reg);
            ototal_reg <= total_reg;
        end
    end

    assign out_valid    = ovalid_reg;
    assign drop         = odrop_reg;
    assign sojourn_time = osoj_reg;
    assign total_drops  = ototal_reg;

    // Once an item is taken, the sequencer is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted while the sequencer stayed idle");

    // Entering the dropping state always leaves a nonzero drop count.
    a_count_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropping_reg) |-> (dc_reg != '0))
        else $error("dropping state entered with a zero drop count");

    // A new result carries the running total as it stands.
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> (ototal_reg == total_reg))
        else $error("result total differs from the drop counter");

    // A dropped burst was at or above the target delay.
    a_drop_above_target: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && odrop_reg) |->
            (osoj_reg >= cdl_pkg::TS_W'(target_reg)))
        else $error("drop reported below the target delay");

endmodule

`default_nettype wire
